// ===== sv/gwm_pkg.sv =====
package gwm_pkg;

  // request opcodes
  localparam logic [1:0] OpPatAppend = 2'd0;
  localparam logic [1:0] OpPatClear  = 2'd1;
  localparam logic [1:0] OpSymAppend = 2'd2;
  localparam logic [1:0] OpEvaluate  = 2'd3;

  localparam logic [7:0] ChAnyOne = 8'h3F;  // '?'
  localparam logic [7:0] ChAnyRun = 8'h2A;  // '*'

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_byte;
  } gwm_req_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } gwm_rsp_t;

  // microprogram addresses
  typedef logic [2:0] step_t;
  localparam step_t StIdle    = 3'd0;
  localparam step_t StFetch   = 3'd1;
  localparam step_t StCmp     = 3'd2;
  localparam step_t StBackChk = 3'd3;
  localparam step_t StTFetch  = 3'd4;
  localparam step_t StTCmp    = 3'd5;
  localparam step_t StDone    = 3'd6;

  typedef enum logic [2:0] {
    TstEval,
    TstSymDone,
    TstPatDone,
    TstHit,
    TstStar,
    TstHaveStar,
    TstOutFree
  } test_e;

  typedef enum logic [2:0] {
    DpNone,
    DpInit,
    DpStep,
    DpBack,
    DpPInc,
    DpPass,
    DpFail,
    DpEmit
  } op_e;

  typedef struct packed {
    test_e test;
    op_e   op_t;
    op_e   op_f;
    step_t next_t;
    step_t next_f;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic eval;
    logic sym_done;
    logic pat_done;
    logic hit;
    logic star;
    logic have_star;
    logic out_free;
  } gwm_cond_t;

  function automatic ctrl_t ucode_rom(input step_t addr);
    ctrl_t w;
    unique case (addr)
      StIdle:    w = '{TstEval,     DpInit, DpNone, StFetch,  StIdle};
      StFetch:   w = '{TstSymDone,  DpNone, DpNone, StTFetch, StCmp};
      StCmp:     w = '{TstHit,      DpStep, DpNone, StFetch,  StBackChk};
      StBackChk: w = '{TstHaveStar, DpBack, DpFail, StFetch,  StDone};
      StTFetch:  w = '{TstPatDone,  DpPass, DpNone, StDone,   StTCmp};
      StTCmp:    w = '{TstStar,     DpPInc, DpFail, StTFetch, StDone};
      StDone:    w = '{TstOutFree,  DpEmit, DpNone, StIdle,   StDone};
      default:   w = '{TstEval,     DpNone, DpNone, StIdle,   StIdle};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/gwm_ram.sv =====
module gwm_ram #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gwm_seq.sv =====
module gwm_seq
  import gwm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  gwm_cond_t cond_i,
  output op_e       op_o,
  output logic      idle_o
);

  step_t step_q, step_d;
  ctrl_t cw;
  logic  take;

  assign cw = ucode_rom(step_q);

  always_comb begin
    case (cw.test)
      TstEval:     take = cond_i.eval;
      TstSymDone:  take = cond_i.sym_done;
      TstPatDone:  take = cond_i.pat_done;
      TstHit:      take = cond_i.hit;
      TstStar:     take = cond_i.star;
      TstHaveStar: take = cond_i.have_star;
      TstOutFree:  take = cond_i.out_free;
      default:     take = 1'b0;
    endcase
  end

  assign step_d = take ? cw.next_t : cw.next_f;
  assign op_o   = take ? cw.op_t : cw.op_f;
  assign idle_o = (step_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== sv/wildcard_glob_matcher.sv =====
// channel | direction | handshake              | payload
// request | in        | in_valid_i / in_stall_o   | in_req_i  (opcode, char_byte)
// result  | out       | out_valid_o / out_stall_i | out_rsp_o (matched, overflow)
//
// Append and clear requests are taken while the block is idle and leave it idle.
// Evaluate runs a microcoded walk over pattern and symbol, backtracking to
// the most recent star, through the single read port of each byte store;
// input is stalled during the walk.
// The result sits in an output register; loads continue while it waits.
// Reset clears counts, overflow flags, the result valid flag and the sequencer, not the stores.
module wildcard_glob_matcher
  import gwm_pkg::*;
#(
  parameter int PATTERN_MAX = 64,
  parameter int SYMBOL_MAX  = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gwm_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gwm_rsp_t out_rsp_o
);

  localparam int PW = $clog2(PATTERN_MAX + 1);
  localparam int SW = $clog2(SYMBOL_MAX + 1);
  localparam int PA = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int SA = (SYMBOL_MAX > 1) ? $clog2(SYMBOL_MAX) : 1;

  logic [PW-1:0] pat_cnt_q, pat_cnt_d;
  logic [SW-1:0] sym_cnt_q, sym_cnt_d;
  logic          pat_ovf_q, pat_ovf_d;
  logic          sym_ovf_q, sym_ovf_d;

  logic [PW-1:0] p_q, p_d, star_p_q, star_p_d;
  logic [SW-1:0] s_q, s_d, star_s_q, star_s_d;
  logic          have_star_q, have_star_d;
  logic          match_q, match_d;

  logic          out_valid_q;
  gwm_rsp_t      out_rsp_q;

  logic          idle;
  logic          in_acc;
  logic          pat_we, sym_we;
  logic [7:0]    pat_rd, sym_rd;
  gwm_cond_t     cond;
  op_e           op;

  assign in_stall_o = !idle;
  assign in_acc     = in_valid_i && idle;
  assign pat_we     = in_acc && (in_req_i.opcode == OpPatAppend) &&
                      (pat_cnt_q < PW'(PATTERN_MAX));
  assign sym_we     = in_acc && (in_req_i.opcode == OpSymAppend) &&
                      (sym_cnt_q < SW'(SYMBOL_MAX));

  gwm_ram #(.Depth(PATTERN_MAX), .AddrW(PA)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_cnt_q[PA-1:0]),
    .wdata_i (in_req_i.char_byte),
    .raddr_i (p_q[PA-1:0]),
    .rdata_o (pat_rd)
  );

  gwm_ram #(.Depth(SYMBOL_MAX), .AddrW(SA)) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (sym_we),
    .waddr_i (sym_cnt_q[SA-1:0]),
    .wdata_i (in_req_i.char_byte),
    .raddr_i (s_q[SA-1:0]),
    .rdata_o (sym_rd)
  );

  // store data is valid in the step after the address was held
  always_comb begin
    cond.eval      = in_valid_i && (in_req_i.opcode == OpEvaluate);
    cond.sym_done  = (s_q >= sym_cnt_q);
    cond.pat_done  = (p_q >= pat_cnt_q);
    cond.star      = (pat_rd == ChAnyRun);
    cond.hit       = !cond.pat_done &&
                     (cond.star || pat_rd == ChAnyOne || pat_rd == sym_rd);
    cond.have_star = have_star_q;
    cond.out_free  = !out_valid_q || !out_stall_i;
  end

  gwm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .op_o   (op),
    .idle_o (idle)
  );

  // load side
  always_comb begin
    pat_cnt_d = pat_cnt_q;
    sym_cnt_d = sym_cnt_q;
    pat_ovf_d = pat_ovf_q;
    sym_ovf_d = sym_ovf_q;
    if (in_acc) begin
      case (in_req_i.opcode)
        OpPatAppend: begin
          if (pat_we) pat_cnt_d = pat_cnt_q + 1'b1;
          else        pat_ovf_d = 1'b1;
        end
        OpPatClear: begin
          pat_cnt_d = '0;
          pat_ovf_d = 1'b0;
        end
        OpSymAppend: begin
          if (sym_we) sym_cnt_d = sym_cnt_q + 1'b1;
          else        sym_ovf_d = 1'b1;
        end
        default: ;
      endcase
    end
    if (op == DpEmit) begin
      sym_cnt_d = '0;
      sym_ovf_d = 1'b0;
    end
  end

  // walk datapath
  always_comb begin
    p_d         = p_q;
    s_d         = s_q;
    star_p_d    = star_p_q;
    star_s_d    = star_s_q;
    have_star_d = have_star_q;
    match_d     = match_q;
    unique case (op)
      DpInit: begin
        p_d         = '0;
        s_d         = '0;
        have_star_d = 1'b0;
      end
      DpStep: begin
        p_d = p_q + 1'b1;
        if (cond.star) begin
          have_star_d = 1'b1;
          star_p_d    = p_q;
          star_s_d    = s_q;
        end else begin
          s_d = s_q + 1'b1;
        end
      end
      DpBack: begin
        p_d      = star_p_q + 1'b1;
        star_s_d = star_s_q + 1'b1;
        s_d      = star_s_q + 1'b1;
      end
      DpPInc: p_d = p_q + 1'b1;
      DpPass: match_d = 1'b1;
      DpFail: match_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_cnt_q   <= '0;
      sym_cnt_q   <= '0;
      pat_ovf_q   <= 1'b0;
      sym_ovf_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pat_cnt_q <= pat_cnt_d;
      sym_cnt_q <= sym_cnt_d;
      pat_ovf_q <= pat_ovf_d;
      sym_ovf_q <= sym_ovf_d;
      if (op == DpEmit)     out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    s_q         <= s_d;
    star_p_q    <= star_p_d;
    star_s_q    <= star_s_d;
    have_star_q <= have_star_d;
    match_q     <= match_d;
    if (op == DpEmit) begin
      out_rsp_q.matched  <= match_q;
      out_rsp_q.overflow <= pat_ovf_q || sym_ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_p_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idle |-> (p_q <= pat_cnt_q))
    else $error("pattern index ran past the pattern count");

  a_s_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idle |-> (s_q <= sym_cnt_q))
    else $error("symbol index ran past the symbol count");

  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == DpEmit) |=> (out_valid_o && sym_cnt_q == '0 && !sym_ovf_q))
    else $error("evaluate did not post a result and empty the symbol store");

endmodule

// ===== tb/wildcard_glob_matcher_test.sv =====
`timescale 1ns / 100ps

module wildcard_glob_matcher_test;
  import gwm_pkg::*;

  localparam int PatDepth   = 64;
  localparam int SymDepth   = 64;
  localparam int ItemTarget = 950;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  gwm_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  gwm_rsp_t out_rsp_o;

  bit steady     = 1'b0;  // no idling on either side while set
  int sent_count = 0;

  wildcard_glob_matcher #(
    .PATTERN_MAX(PatDepth),
    .SYMBOL_MAX (SymDepth)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Mirrors both byte stores and the overflow flags, queues one verdict per evaluate.
  class glob_match_tracker;
    logic [7:0] pat_bytes[PatDepth];
    logic [7:0] sym_bytes[SymDepth];
    int         pat_len;
    int         sym_len;
    bit         pat_lost;
    bit         sym_lost;
    gwm_rsp_t   pending_verdicts[$];
    int         mismatch_count;

    function new();
      pat_len = 0;
      sym_len = 0;
      pat_lost = 1'b0;
      sym_lost = 1'b0;
      mismatch_count = 0;
    endfunction

    // greedy walk, backtracking to the most recent star only
    function bit pattern_covers_symbol();
      int pi, si, star_pi, star_si;
      bit star_seen;
      pi = 0;
      si = 0;
      star_pi = 0;
      star_si = 0;
      star_seen = 1'b0;
      while (si < sym_len) begin
        if (pi < pat_len && pat_bytes[pi] == ChAnyRun) begin
          star_seen = 1'b1;
          star_pi = pi;
          star_si = si;
          pi++;
        end else if (pi < pat_len &&
                     (pat_bytes[pi] == ChAnyOne || pat_bytes[pi] == sym_bytes[si])) begin
          pi++;
          si++;
        end else if (star_seen) begin
          pi = star_pi + 1;
          star_si++;
          si = star_si;
        end else begin
          return 1'b0;
        end
      end
      while (pi < pat_len && pat_bytes[pi] == ChAnyRun) pi++;
      return pi == pat_len;
    endfunction

    function void absorb_request(gwm_req_t req);
      gwm_rsp_t verdict;
      case (req.opcode)
        OpPatAppend: begin
          if (pat_len < PatDepth) begin
            pat_bytes[pat_len] = req.char_byte;
            pat_len++;
          end else begin
            pat_lost = 1'b1;
          end
        end
        OpPatClear: begin
          pat_len = 0;
          pat_lost = 1'b0;
        end
        OpSymAppend: begin
          if (sym_len < SymDepth) begin
            sym_bytes[sym_len] = req.char_byte;
            sym_len++;
          end else begin
            sym_lost = 1'b1;
          end
        end
        default: begin
          verdict.matched = pattern_covers_symbol();
          verdict.overflow = pat_lost | sym_lost;
          pending_verdicts.push_back(verdict);
          sym_len = 0;
          sym_lost = 1'b0;
        end
      endcase
    endfunction

    function void compare_verdict(gwm_rsp_t got);
      gwm_rsp_t want;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: matched %0d overflow %0d", got.matched, got.overflow);
        mismatch_count++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.matched !== want.matched) begin
        $error("matched: expected %0d, got %0d", want.matched, got.matched);
        mismatch_count++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

  glob_match_tracker tracker = new();

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] rand_byte();
    bit [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic gwm_req_t rand_req();
    bit [31:0] r;
    r = $urandom;
    return gwm_req_t'(r[9:0]);
  endfunction

  // small alphabet so literals collide often
  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return "a";
    if (roll < 70) return "b";
    if (roll < 80) return "c";
    return rand_byte();
  endfunction

  function automatic logic [7:0] pick_pat_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return ChAnyRun;
    if (roll < 40) return ChAnyOne;
    return pick_char();
  endfunction

  // mostly short strings, a few past the store depth
  function automatic int pick_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return $urandom_range(60, 70);
    if (roll < 15) return $urandom_range(9, 20);
    return $urandom_range(0, 8);
  endfunction

  task automatic send_req(input logic [1:0] op, input logic [7:0] b);
    gwm_req_t req;
    req.opcode = op;
    req.char_byte = b;
    if (!steady && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      in_req_i <= rand_req();
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    tracker.absorb_request(req);
    sent_count++;
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin : result_sink
    int seen;
    int hold;
    seen = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        tracker.compare_verdict(out_rsp_o);
        seen++;
        if (seen == 12) hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (steady) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 30);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] cur_pat[$];
    logic [7:0] sym[$];
    gwm_req_t   junk;
    int         roll, evals, len, k, m;
    bit         have_pat;

    have_pat = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pattern vs empty symbol
    send_req(OpEvaluate, 8'h00);
    send_req(OpEvaluate, 8'hFF);
    // lone star matches the empty symbol and a star byte
    send_req(OpPatAppend, ChAnyRun);
    send_req(OpEvaluate, 8'h00);
    send_req(OpSymAppend, ChAnyRun);
    send_req(OpEvaluate, 8'h00);
    send_req(OpPatAppend, ChAnyOne);
    send_req(OpSymAppend, 8'hFF);
    send_req(OpEvaluate, 8'h00);
    send_req(OpEvaluate, 8'h00);
    // plain literals at both byte extremes
    send_req(OpPatClear, 8'hFF);
    send_req(OpPatAppend, 8'h00);
    send_req(OpSymAppend, 8'h00);
    send_req(OpEvaluate, 8'h00);
    send_req(OpSymAppend, 8'hFF);
    send_req(OpEvaluate, 8'hFF);
    send_req(OpPatAppend, 8'hFF);
    send_req(OpSymAppend, 8'h00);
    send_req(OpSymAppend, 8'hFF);
    send_req(OpEvaluate, 8'h55);
    send_req(OpPatClear, 8'h00);

    while (sent_count < ItemTarget) begin
      steady = (sent_count >= 350 && sent_count < 600);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        m = $urandom_range(1, 4);
        for (k = 0; k < m; k++) begin
          junk = rand_req();
          send_req(junk.opcode, junk.char_byte);
        end
      end else begin
        if (roll < 35 || !have_pat) begin
          send_req(OpPatClear, rand_byte());
          cur_pat.delete();
          len = pick_len();
          for (k = 0; k < len; k++) begin
            cur_pat.push_back(pick_pat_char());
            send_req(OpPatAppend, cur_pat[k]);
          end
          have_pat = 1'b1;
        end
        evals = $urandom_range(1, 3);
        repeat (evals) begin
          sym.delete();
          if ($urandom_range(0, 99) < 60) begin
            // build a symbol the pattern should accept, then maybe spoil it
            foreach (cur_pat[i]) begin
              if (cur_pat[i] == ChAnyRun) begin
                repeat ($urandom_range(0, 3)) sym.push_back(pick_char());
              end else if (cur_pat[i] == ChAnyOne) begin
                sym.push_back(rand_byte());
              end else begin
                sym.push_back(cur_pat[i]);
              end
            end
            m = $urandom_range(0, 99);
            if (m < 30 && sym.size() > 0) begin
              sym[$urandom_range(0, sym.size() - 1)] = pick_char();
            end else if (m < 40) begin
              sym.push_back(pick_char());
            end
          end else begin
            len = pick_len();
            repeat (len) sym.push_back(pick_char());
          end
          foreach (sym[i]) send_req(OpSymAppend, sym[i]);
          send_req(OpEvaluate, rand_byte());
        end
      end
    end

    steady = 1'b0;
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (tracker.mismatch_count == 0) begin
      $display("wildcard_glob_matcher_test: done, clean");
    end else begin
      $display("wildcard_glob_matcher_test: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("wildcard_glob_matcher_test: done, errors");
    $finish;
  end

endmodule

// ===== wildcard_glob_matcher.f =====
sv/gwm_pkg.sv
sv/gwm_ram.sv
sv/gwm_seq.sv
sv/wildcard_glob_matcher.sv
tb/wildcard_glob_matcher_test.sv
